// ===== rtl/rtli_pkg.sv =====
package rtli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Command codes
    localparam logic [2:0] CMD_WRITE       = 3'd0;
    localparam logic [2:0] CMD_BOTH        = 3'd1;
    localparam logic [2:0] CMD_INNER_FLOOR = 3'd2;
    localparam logic [2:0] CMD_OUTER_FLOOR = 3'd3;
    localparam logic [2:0] CMD_PANO        = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NEG      = 2'd2;
    localparam logic [1:0] ST_PARALLEL = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_INDEX_SCALE      = 3'd0;
    localparam logic [2:0] REG_INNER_RING_START = 3'd1;
    localparam logic [2:0] REG_INNER_RING_END   = 3'd2;
    localparam logic [2:0] REG_OUTER_RING_END   = 3'd3;
    localparam logic [2:0] REG_CAMERA_HEIGHT    = 3'd4;

    localparam int RAD_W    = 19;               // signed radius, Q15.4
    localparam int PROD_W   = 42;               // radius * scale, Q22.20
    localparam int NUM_W    = 65;               // dividend magnitude
    localparam int DEN_W    = 33;               // divisor magnitude
    localparam int DIV_BITS = 34;               // quotient bits before saturation
    localparam int CMP_W    = DEN_W + DIV_BITS; // shifted divisor compare width
    localparam int SUM_W    = DIV_BITS + 3;     // signed result before saturation

    typedef struct packed {
        logic [2:0]         command;
        logic [9:0]         entry_index;
        logic signed [31:0] slope_value;
        logic signed [31:0] offset_value;
        logic [15:0]        inner_radius;
        logic [15:0]        outer_radius;
        logic [11:0]        inner_row;
        logic [11:0]        outer_row;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] ground_distance;
        logic signed [31:0] point_height;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic [23:0] index_scale;
        logic [11:0] inner_ring_start;
        logic [11:0] inner_ring_end;
        logic [11:0] outer_ring_end;
        logic [30:0] camera_height;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [1:0]         st1;
        logic [1:0]         st2;
        logic signed [31:0] sl1;
        logic signed [31:0] of1;
        logic signed [31:0] sl2;
        logic signed [31:0] of2;
    } t_lines;

    typedef struct packed {
        logic signed [31:0] b1;
        logic [1:0]         st;
        logic               sq;
        logic               sh;
        logic               ovq;
        logic               ovh;
    } t_side;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (!v[SUM_W-1] && (v[SUM_W-2:31] != '0)) begin
            r = 32'sh7fffffff;
        end else if (v[SUM_W-1] && (v[SUM_W-2:31] != '1)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rtli_lookup.sv =====
module rtli_lookup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rtli_pkg::t_in_item i_item,
    input  rtli_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output rtli_pkg::t_lines  o_lines
);
    import rtli_pkg::*;

    logic signed [31:0] r_slope_mem  [TABLE_DEPTH];
    logic signed [31:0] r_offset_mem [TABLE_DEPTH];

    // stage A: radii
    logic               r_a_v;
    logic [2:0]         r_a_cmd;
    logic [9:0]         r_a_e;
    logic signed [31:0] r_a_sl, r_a_of;
    logic signed [RAD_W-1:0] r_a_r1, r_a_r2;
    logic signed [RAD_W-1:0] n_a_r1, n_a_r2;
    logic signed [14:0] pi, po;

    // stage B: scaled radii
    logic               r_b_v;
    logic [2:0]         r_b_cmd;
    logic [9:0]         r_b_e;
    logic signed [31:0] r_b_sl, r_b_of;
    logic               r_b_neg1, r_b_neg2;
    logic [PROD_W-1:0]  r_b_p1, r_b_p2;

    // stage C: table read
    logic               r_c_v;
    logic [PROD_W-1:0]  idx1, idx2;
    logic [1:0]         n_st1, n_st2;
    logic               wr_ok;

    // Work out the two radii
    always_comb begin
        pi = $signed({3'b0, i_cfg.inner_ring_end}) - $signed({3'b0, i_item.inner_row});
        po = $signed({3'b0, i_item.outer_row})
           - ($signed({3'b0, i_cfg.inner_ring_end}) - $signed({3'b0, i_cfg.inner_ring_start}))
           + $signed({3'b0, i_cfg.outer_ring_end});
        if (i_item.command == CMD_PANO) begin
            n_a_r1 = {pi, 4'b0};
            n_a_r2 = {po, 4'b0};
        end else begin
            n_a_r1 = $signed({3'b0, i_item.inner_radius});
            n_a_r2 = $signed({3'b0, i_item.outer_radius});
        end
    end

    // Round to a table index and check each line
    always_comb begin
        idx1  = (r_b_p1 + PROD_W'(1 << 19)) >> 20;
        idx2  = (r_b_p2 + PROD_W'(1 << 19)) >> 20;
        n_st1 = r_b_neg1 ? ST_NEG : (idx1 >= PROD_W'(TABLE_DEPTH)) ? ST_RANGE : ST_OK;
        n_st2 = r_b_neg2 ? ST_NEG : (idx2 >= PROD_W'(TABLE_DEPTH)) ? ST_RANGE : ST_OK;
        wr_ok = r_b_v && (r_b_cmd == CMD_WRITE) && (32'(r_b_e) < TABLE_DEPTH);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid && (i_item.command <= CMD_PANO);
            r_b_v <= r_a_v;
            r_c_v <= r_b_v && (r_b_cmd != CMD_WRITE);
        end
    end

    // Payload, table write and registered table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cmd  <= i_item.command;
            r_a_e    <= i_item.entry_index;
            r_a_sl   <= i_item.slope_value;
            r_a_of   <= i_item.offset_value;
            r_a_r1   <= n_a_r1;
            r_a_r2   <= n_a_r2;

            r_b_cmd  <= r_a_cmd;
            r_b_e    <= r_a_e;
            r_b_sl   <= r_a_sl;
            r_b_of   <= r_a_of;
            r_b_neg1 <= r_a_r1[RAD_W-1];
            r_b_neg2 <= r_a_r2[RAD_W-1];
            r_b_p1   <= PROD_W'(r_a_r1[RAD_W-2:0]) * PROD_W'(i_cfg.index_scale);
            r_b_p2   <= PROD_W'(r_a_r2[RAD_W-2:0]) * PROD_W'(i_cfg.index_scale);

            if (wr_ok) begin
                r_slope_mem[IDX_W'(r_b_e)]  <= r_b_sl;
                r_offset_mem[IDX_W'(r_b_e)] <= r_b_of;
            end
            o_lines.cmd <= r_b_cmd;
            o_lines.st1 <= n_st1;
            o_lines.st2 <= n_st2;
            o_lines.sl1 <= r_slope_mem[idx1[IDX_W-1:0]];
            o_lines.of1 <= r_offset_mem[idx1[IDX_W-1:0]];
            o_lines.sl2 <= r_slope_mem[idx2[IDX_W-1:0]];
            o_lines.of2 <= r_offset_mem[idx2[IDX_W-1:0]];
        end
    end

    assign o_valid = r_c_v;

endmodule

// ===== rtl/rtli_prep.sv =====
module rtli_prep (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rtli_pkg::t_lines            i_lines,
    input  logic [30:0]                 i_camera_height,
    output logic                        o_valid,
    output logic [rtli_pkg::NUM_W-1:0]  o_nq,
    output logic [rtli_pkg::NUM_W-1:0]  o_nh,
    output logic [rtli_pkg::DEN_W-1:0]  o_d,
    output rtli_pkg::t_side             o_side
);
    import rtli_pkg::*;

    logic signed [31:0] floor_b;
    logic signed [31:0] n_a1, n_b1, n_a2, n_b2;
    logic [1:0]         s1, s2, n_st;

    // stage D: chosen lines and differences
    logic               r_d_v;
    logic signed [31:0] r_d_a1, r_d_b1;
    logic signed [32:0] r_d_da, r_d_db;
    logic [1:0]         r_d_st;

    // stage E: product
    logic               r_e_v;
    logic signed [64:0] r_e_prod;
    logic signed [32:0] r_e_da, r_e_db;
    logic signed [31:0] r_e_b1;
    logic [1:0]         r_e_st;

    // stage F: magnitudes
    logic               r_f_v;
    logic [NUM_W-1:0]   r_f_nq, r_f_nh;
    logic [DEN_W-1:0]   r_f_d;
    logic               r_f_sq, r_f_sh;
    logic signed [31:0] r_f_b1;
    logic [1:0]         r_f_st;

    logic [DEN_W-1:0]   abs_db;

    // Pick the lines, the floor standing in where the command asks
    always_comb begin
        floor_b = -$signed({1'b0, i_camera_height});
        n_a1 = (i_lines.cmd == CMD_OUTER_FLOOR) ? 32'sd0 : i_lines.sl1;
        n_b1 = (i_lines.cmd == CMD_OUTER_FLOOR) ? floor_b : i_lines.of1;
        n_a2 = (i_lines.cmd == CMD_INNER_FLOOR) ? 32'sd0 : i_lines.sl2;
        n_b2 = (i_lines.cmd == CMD_INNER_FLOOR) ? floor_b : i_lines.of2;
        s1   = (i_lines.cmd == CMD_OUTER_FLOOR) ? ST_OK : i_lines.st1;
        s2   = (i_lines.cmd == CMD_INNER_FLOOR) ? ST_OK : i_lines.st2;
        if (s1 != ST_OK) begin
            n_st = s1;
        end else if (s2 != ST_OK) begin
            n_st = s2;
        end else if (n_a1 == n_a2) begin
            n_st = ST_PARALLEL;
        end else begin
            n_st = ST_OK;
        end
        abs_db = r_e_db[32] ? DEN_W'(-r_e_db) : DEN_W'(r_e_db);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_f_v   <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_d_v   <= i_valid;
            r_e_v   <= r_d_v;
            r_f_v   <= r_e_v;
            o_valid <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_a1   <= n_a1;
            r_d_b1   <= n_b1;
            r_d_da   <= 33'(n_a1) - 33'(n_a2);
            r_d_db   <= 33'(n_b2) - 33'(n_b1);
            r_d_st   <= n_st;

            r_e_prod <= 65'(r_d_a1) * 65'(r_d_db);
            r_e_da   <= r_d_da;
            r_e_db   <= r_d_db;
            r_e_b1   <= r_d_b1;
            r_e_st   <= r_d_st;

            r_f_nq   <= NUM_W'(abs_db) << 24;
            r_f_nh   <= r_e_prod[64] ? NUM_W'(-r_e_prod) : NUM_W'(r_e_prod);
            r_f_d    <= r_e_da[32] ? DEN_W'(-r_e_da) : DEN_W'(r_e_da);
            r_f_sq   <= r_e_db[32] ^ r_e_da[32];
            r_f_sh   <= r_e_prod[64] ^ r_e_da[32];
            r_f_b1   <= r_e_b1;
            r_f_st   <= r_e_st;

            // flag quotients too large for the divider's bits
            o_nq       <= r_f_nq;
            o_nh       <= r_f_nh;
            o_d        <= r_f_d;
            o_side.b1  <= r_f_b1;
            o_side.st  <= r_f_st;
            o_side.sq  <= r_f_sq;
            o_side.sh  <= r_f_sh;
            o_side.ovq <= CMP_W'(r_f_nq) >= (CMP_W'(r_f_d) << DIV_BITS);
            o_side.ovh <= CMP_W'(r_f_nh) >= (CMP_W'(r_f_d) << DIV_BITS);
        end
    end

endmodule

// ===== rtl/rtli_div.sv =====
module rtli_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rtli_pkg::NUM_W-1:0]    i_nq,
    input  logic [rtli_pkg::NUM_W-1:0]    i_nh,
    input  logic [rtli_pkg::DEN_W-1:0]    i_d,
    input  rtli_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [rtli_pkg::DIV_BITS-1:0] o_qq,
    output logic [rtli_pkg::DIV_BITS-1:0] o_qh,
    output rtli_pkg::t_side               o_side
);
    import rtli_pkg::*;

    // one quotient bit per stage, both quotients share the divisor
    logic                r_v    [DIV_BITS];
    logic [NUM_W-1:0]    r_remq [DIV_BITS];
    logic [NUM_W-1:0]    r_remh [DIV_BITS];
    logic [DIV_BITS-1:0] r_qq   [DIV_BITS];
    logic [DIV_BITS-1:0] r_qh   [DIV_BITS];
    logic [DEN_W-1:0]    r_d    [DIV_BITS];
    t_side               r_side [DIV_BITS];

    logic                c_v    [DIV_BITS];
    logic [NUM_W-1:0]    c_remq [DIV_BITS];
    logic [NUM_W-1:0]    c_remh [DIV_BITS];
    logic [DIV_BITS-1:0] c_qq   [DIV_BITS];
    logic [DIV_BITS-1:0] c_qh   [DIV_BITS];
    logic [DEN_W-1:0]    c_d    [DIV_BITS];
    t_side               c_side [DIV_BITS];

    logic [CMP_W-1:0]    sh_d   [DIV_BITS];
    logic                geq    [DIV_BITS];
    logic                geh    [DIV_BITS];

    // Route each stage's source
    always_comb begin
        for (int k = 0; k < DIV_BITS; k++) begin
            if (k == 0) begin
                c_v[k]    = i_valid;
                c_remq[k] = i_nq;
                c_remh[k] = i_nh;
                c_qq[k]   = '0;
                c_qh[k]   = '0;
                c_d[k]    = i_d;
                c_side[k] = i_side;
            end else begin
                c_v[k]    = r_v[k-1];
                c_remq[k] = r_remq[k-1];
                c_remh[k] = r_remh[k-1];
                c_qq[k]   = r_qq[k-1];
                c_qh[k]   = r_qh[k-1];
                c_d[k]    = r_d[k-1];
                c_side[k] = r_side[k-1];
            end
            sh_d[k] = CMP_W'(c_d[k]) << (DIV_BITS - 1 - k);
            geq[k]  = CMP_W'(c_remq[k]) >= sh_d[k];
            geh[k]  = CMP_W'(c_remh[k]) >= sh_d[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_BITS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < DIV_BITS; k++) begin
                r_v[k] <= c_v[k];
            end
        end
    end

    // Compare, subtract and set the quotient bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_BITS; k++) begin
                r_remq[k] <= geq[k] ? NUM_W'(CMP_W'(c_remq[k]) - sh_d[k]) : c_remq[k];
                r_remh[k] <= geh[k] ? NUM_W'(CMP_W'(c_remh[k]) - sh_d[k]) : c_remh[k];
                r_qq[k]   <= c_qq[k] | (geq[k] ? (DIV_BITS'(1) << (DIV_BITS - 1 - k)) : '0);
                r_qh[k]   <= c_qh[k] | (geh[k] ? (DIV_BITS'(1) << (DIV_BITS - 1 - k)) : '0);
                r_d[k]    <= c_d[k];
                r_side[k] <= c_side[k];
            end
        end
    end

    assign o_valid = r_v[DIV_BITS-1];
    assign o_qq    = r_qq[DIV_BITS-1];
    assign o_qh    = r_qh[DIV_BITS-1];
    assign o_side  = r_side[DIV_BITS-1];

endmodule

// ===== rtl/ray_table_line_intersection.sv =====
// Ray table line intersection. Write items (command 0) fill a 1024-entry table of ray
// lines and give no result; each query gives one result item. The pipeline takes one
// item every cycle unless o_stall is high. Three stages compute radii, scale them and
// read the table (one dual-read block RAM per field), four prepare the operands, and a
// 34-stage restoring divider produces one quotient bit per stage for distance and
// height in parallel. An output register with a one-entry skid buffer sits at the
// result side; the input stalls only while the skid buffer is full. Configuration
// must be written through the cfg port only while no query is in flight; the block
// does not enforce this. The cfg port is always ready.
module ray_table_line_intersection (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rtli_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output rtli_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import rtli_pkg::*;

    t_cfg       r_cfg;
    logic       en;

    logic       lk_v;
    t_lines     lk_lines;
    logic       pp_v;
    logic [NUM_W-1:0] pp_nq, pp_nh;
    logic [DEN_W-1:0] pp_d;
    t_side      pp_side;
    logic       dv_v;
    logic [DIV_BITS-1:0] dv_qq, dv_qh;
    t_side      dv_side;

    logic signed [DIV_BITS+1:0] qs, hs;
    logic signed [SUM_W-1:0]    hsum;
    t_out_item  res;

    logic       r_out_v, r_skid_v;
    t_out_item  r_out, r_skid;

    assign en          = !r_skid_v;
    assign o_stall     = r_skid_v;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.index_scale      <= 24'd65536;
            r_cfg.inner_ring_start <= '0;
            r_cfg.inner_ring_end   <= '0;
            r_cfg.outer_ring_end   <= '0;
            r_cfg.camera_height    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INDEX_SCALE:      r_cfg.index_scale      <= i_cfg_data[23:0];
                REG_INNER_RING_START: r_cfg.inner_ring_start <= i_cfg_data[11:0];
                REG_INNER_RING_END:   r_cfg.inner_ring_end   <= i_cfg_data[11:0];
                REG_OUTER_RING_END:   r_cfg.outer_ring_end   <= i_cfg_data[11:0];
                REG_CAMERA_HEIGHT:    r_cfg.camera_height    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    rtli_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (lk_v),
        .o_lines (lk_lines)
    );

    rtli_prep u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_valid         (lk_v),
        .i_lines         (lk_lines),
        .i_camera_height (r_cfg.camera_height),
        .o_valid         (pp_v),
        .o_nq            (pp_nq),
        .o_nh            (pp_nh),
        .o_d             (pp_d),
        .o_side          (pp_side)
    );

    rtli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pp_v),
        .i_nq    (pp_nq),
        .i_nh    (pp_nh),
        .i_d     (pp_d),
        .i_side  (pp_side),
        .o_valid (dv_v),
        .o_qq    (dv_qq),
        .o_qh    (dv_qh),
        .o_side  (dv_side)
    );

    // Apply signs, add the offset and saturate
    always_comb begin
        qs = dv_side.sq ? -$signed({2'b0, dv_qq}) : $signed({2'b0, dv_qq});
        if (dv_side.ovh) begin
            hs = dv_side.sh ? -$signed({2'b01, {DIV_BITS{1'b0}}})
                            :  $signed({2'b01, {DIV_BITS{1'b0}}});
        end else begin
            hs = dv_side.sh ? -$signed({2'b0, dv_qh}) : $signed({2'b0, dv_qh});
        end
        hsum = SUM_W'(hs) + SUM_W'(dv_side.b1);
        res.status = dv_side.st;
        if (dv_side.st != ST_OK) begin
            res.ground_distance = '0;
            res.point_height    = '0;
        end else begin
            if (dv_side.ovq) begin
                res.ground_distance = dv_side.sq ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
                res.ground_distance = sat32(SUM_W'(qs));
            end
            res.point_height = sat32(hsum);
        end
    end

    // Output register with skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= dv_v;
            end
        end else if (dv_v && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (dv_v && en) begin
            r_skid <= res;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid buffer holds an item with the output register empty");

    a_skid_catch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall && dv_v && !r_skid_v) |=> r_skid_v)
        else $error("result lost while output stalled");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_item.status != ST_OK)) |->
            (o_item.ground_distance == 0 && o_item.point_height == 0))
        else $error("error result carries non-zero fields");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rtli_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 115;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    ray_table_line_intersection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: line table and register copy
    logic signed [31:0] slope_tab [TABLE_DEPTH];
    logic signed [31:0] offset_tab [TABLE_DEPTH];
    t_cfg               cfg_copy;

    t_out_item pending_results[$];
    int        idle_pct;
    int        stall_pct;
    int        mismatches;
    int        quiet_cycles;
    bit        timed_out;

    // Directed rows
    t_in_item  row_item[$];
    bit        row_typed[$];
    t_out_item row_result[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Map a Q12.4 radius to a table line, or give the error status
    function automatic logic [1:0] ray_lookup(input longint rq, output longint a,
                                              output longint b);
        longint idx;
        a = 0;
        b = 0;
        if (rq < 0) return ST_NEG;
        idx = (rq * longint'(cfg_copy.index_scale) + (64'sd1 <<< 19)) >>> 20;
        if (idx >= TABLE_DEPTH) return ST_RANGE;
        a = longint'(slope_tab[idx]);
        b = longint'(offset_tab[idx]);
        return ST_OK;
    endfunction

    // Update the table or work out the intersection; returns 1 when a result follows
    function automatic bit predict_intersection(input t_in_item it, output t_out_item r);
        longint a1, b1, a2, b2, r1, r2, floor_b, da, db, h;
        logic [1:0] st;
        r = '0;
        if (it.command == CMD_WRITE) begin
            slope_tab[it.entry_index] = it.slope_value;
            offset_tab[it.entry_index] = it.offset_value;
            return 1'b0;
        end
        if (it.command > CMD_PANO) return 1'b0;
        floor_b = -longint'(cfg_copy.camera_height);
        a1 = 0; b1 = 0; a2 = 0; b2 = 0;
        st = ST_OK;
        if (it.command == CMD_PANO) begin
            r1 = (longint'(cfg_copy.inner_ring_end) - longint'(it.inner_row)) * 16;
            r2 = (longint'(it.outer_row) - (longint'(cfg_copy.inner_ring_end)
                  - longint'(cfg_copy.inner_ring_start))
                  + longint'(cfg_copy.outer_ring_end)) * 16;
        end else begin
            r1 = longint'(it.inner_radius);
            r2 = longint'(it.outer_radius);
        end
        if (it.command == CMD_OUTER_FLOOR) begin
            b1 = floor_b;
        end else begin
            st = ray_lookup(r1, a1, b1);
        end
        if (st == ST_OK) begin
            if (it.command == CMD_INNER_FLOOR) begin
                b2 = floor_b;
            end else begin
                st = ray_lookup(r2, a2, b2);
            end
        end
        if (st == ST_OK && a1 == a2) st = ST_PARALLEL;
        if (st == ST_OK) begin
            da = a1 - a2;
            db = b2 - b1;
            h = (a1 * db) / da;
            if (h > (64'sd1 <<< 40)) h = 64'sd1 <<< 40;
            if (h < -(64'sd1 <<< 40)) h = -(64'sd1 <<< 40);
            r.ground_distance = clamp32((db * 64'sd16777216) / da);
            r.point_height = clamp32(h + b1);
        end
        r.status = st;
        return 1'b1;
    endfunction

    // Offer one item, honouring the idle rate, and predict it once taken
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (predict_intersection(it, res)) begin
            pending_results.push_back(typed ? typed_res : res);
        end
    endtask

    task automatic add_row(input t_in_item it, input bit typed, input t_out_item res);
        row_item.push_back(it);
        row_typed.push_back(typed);
        row_result.push_back(res);
    endtask

    // Write one register; the caller lowers valid after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_INDEX_SCALE:      cfg_copy.index_scale = data[23:0];
            REG_INNER_RING_START: cfg_copy.inner_ring_start = data[11:0];
            REG_INNER_RING_END:   cfg_copy.inner_ring_end = data[11:0];
            REG_OUTER_RING_END:   cfg_copy.outer_ring_end = data[11:0];
            REG_CAMERA_HEIGHT:    cfg_copy.camera_height = data[30:0];
            default: ;
        endcase
    endtask

    // Hold the sender until every result is back, then let the pipe empty
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item     it;
        logic [159:0] raw;
        int           pick;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.command = CMD_WRITE;
            // coarse slopes now and then so parallel lines turn up
            if ($urandom_range(2) == 0) it.slope_value = $signed($urandom_range(3) << 24);
        end else if (pick < 95) begin
            it.command = 3'($urandom_range(CMD_BOTH, CMD_PANO));
        end else begin
            it.command = 3'($urandom_range(5, 7));
        end
        if ($urandom_range(1)) it.inner_radius = 16'($urandom_range(2000));
        if ($urandom_range(1)) it.outer_radius = 16'($urandom_range(2000));
        return it;
    endfunction

    // Stall the result side at the phase's rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_item);
            end else begin
                want = pending_results.pop_front();
                if (o_item.ground_distance !== want.ground_distance
                    || o_item.point_height !== want.point_height
                    || o_item.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected dist %0d height %0d status %0d, got %0d %0d %0d",
                                 want.ground_distance, want.point_height, want.status,
                                 o_item.ground_distance, o_item.point_height, o_item.status);
                    end
                end
            end
        end
    end

    // Count cycles with no traffic at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item res;
        t_out_item none;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        none = '0;
        cfg_copy = '0;
        cfg_copy.index_scale = 24'd65536;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; reset scale maps radius R to entry round(R/16)
        it = '0;
        it.command = CMD_WRITE;
        it.entry_index = 0; it.slope_value = 32'sh01000000; it.offset_value = 0;
        add_row(it, 0, none);
        it.entry_index = 1; it.slope_value = 0; it.offset_value = 32'sh00010000;
        add_row(it, 0, none);
        it.entry_index = 2; it.slope_value = 32'sh01000000; it.offset_value = 32'sh00050000;
        add_row(it, 0, none);
        it.entry_index = 3; it.slope_value = 32'sh01000000; it.offset_value = -32'sh00030000;
        add_row(it, 0, none);
        it.entry_index = 4; it.slope_value = 32'sh7fffffff; it.offset_value = 32'sh80000000;
        add_row(it, 0, none);
        it.entry_index = 5; it.slope_value = 32'sh80000000; it.offset_value = 32'sh7fffffff;
        add_row(it, 0, none);
        it = '0;
        it.command = CMD_BOTH; it.inner_radius = 0; it.outer_radius = 16;
        add_row(it, 0, none);
        it.inner_radius = 64; it.outer_radius = 80;
        add_row(it, 0, none);
        it.inner_radius = 80; it.outer_radius = 64;
        add_row(it, 0, none);
        // parallel lines
        res = '0; res.status = ST_PARALLEL;
        it.inner_radius = 32; it.outer_radius = 48;
        add_row(it, 1, res);
        // index beyond the table on the first line, then on the second
        res.status = ST_RANGE;
        it.inner_radius = 16'hffff; it.outer_radius = 0;
        add_row(it, 1, res);
        it.inner_radius = 0; it.outer_radius = 16'hffff;
        add_row(it, 1, res);
        it.command = CMD_INNER_FLOOR; it.inner_radius = 64;
        add_row(it, 0, none);
        it.command = CMD_OUTER_FLOOR; it.outer_radius = 80;
        add_row(it, 0, none);
        it.outer_radius = 16'hffff;
        add_row(it, 1, res);
        it.command = CMD_INNER_FLOOR; it.inner_radius = 0;
        add_row(it, 0, none);
        // panorama with reset rings: row 0 gives entry 0, a negative radius otherwise
        it = '0;
        it.command = CMD_PANO; it.inner_row = 0; it.outer_row = 1;
        add_row(it, 0, none);
        res.status = ST_NEG;
        it.inner_row = 12'hfff; it.outer_row = 12'hfff;
        add_row(it, 1, res);
        // unknown commands give nothing
        for (int c = 5; c <= 7; c++) begin
            it = '1;
            it.command = 3'(c);
            add_row(it, 0, none);
        end
        foreach (row_item[n]) send_item(row_item[n], row_typed[n], row_result[n]);

        // Fill the whole table so every later query reads written lines
        for (int e = 0; e < TABLE_DEPTH; e++) begin
            it = random_item();
            it.command = CMD_WRITE;
            it.entry_index = 10'(e);
            send_item(it, 0, none);
        end

        // Random phases, each with its own register setting and an idle and stall pattern
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_INDEX_SCALE, 32'h00ffffff);
                    write_reg(REG_INNER_RING_START, 32'hfff);
                    write_reg(REG_INNER_RING_END, 32'hfff);
                    write_reg(REG_OUTER_RING_END, 32'hfff);
                    write_reg(REG_CAMERA_HEIGHT, 32'h7fffffff);
                end
                1: begin
                    write_reg(REG_INDEX_SCALE, 32'h0);
                    write_reg(REG_INNER_RING_START, 32'h0);
                    write_reg(REG_INNER_RING_END, 32'h0);
                    write_reg(REG_OUTER_RING_END, 32'h0);
                    write_reg(REG_CAMERA_HEIGHT, 32'h0);
                end
                default: begin
                    write_reg(REG_INDEX_SCALE, $urandom_range(1) ? $urandom_range(4096, 1 << 18)
                                                                 : $urandom);
                    write_reg(REG_INNER_RING_START, $urandom_range(4095));
                    write_reg(REG_INNER_RING_END, $urandom_range(4095));
                    write_reg(REG_OUTER_RING_END, $urandom_range(4095));
                    write_reg(REG_CAMERA_HEIGHT, $urandom);
                end
            endcase
            i_cfg_valid <= 1'b0;
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 0, none);
        end

        // Wait out the tail
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
